>>> rtl/dfl_pkg.sv
package dfl_pkg;

  // address split
  localparam int unsigned ADDR_SPAN_BITS = 8;
  localparam int unsigned OFFSET_BITS    = 2;
  localparam int unsigned BLOCK_WORDS    = 1 << OFFSET_BITS;
  localparam int unsigned BLOCK_BITS     = ADDR_SPAN_BITS - OFFSET_BITS;

  // line store, LINES is a power of two
  localparam int unsigned LINES      = 4;
  localparam int unsigned LINE_W     = (LINES > 2) ? 2 : 1;
  localparam int unsigned INDEX_BITS = LINE_W;
  localparam int unsigned TAG_W      = BLOCK_BITS;

  // hit counters
  localparam int unsigned COUNT_BITS = 16;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // fixed field widths
  localparam int unsigned ADDR_W = 16;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned ROW_W  = WORD_W * BLOCK_WORDS;
  localparam int unsigned USED_W = 2;

  // mapping modes
  localparam logic MODE_DIRECT = 1'b0;
  localparam logic MODE_ASSOC  = 1'b1;

  // register indexes
  localparam int unsigned REG_MAPPING_MODE = 0;

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } state_e;

endpackage

>>> rtl/dm_fa_lfu_read_cache.sv
// read-only cache, direct-mapped or fully associative with lfu replacement
//
// request channel: in_valid_i/in_ready_o carries an address and the four
// words of the memory block that holds it; the words are used only on a miss.
// result channel: out_valid_o/out_ready_i carries read_data, hit, replaced,
// failed and line_used for every request, in order.
// configuration: apb-style port, one register (mapping_mode) at byte 0;
// write it only while no request is in flight.
//
// each request is handled in an accept cycle and a response cycle: the accept
// cycle compares tags, picks the line and writes tags, counters and the refill
// row; the response cycle reads the registered data row of the block memory and
// loads the output register. a new request is taken once that load is done.
// when the receiver stalls, one finished result waits in the output register
// and one more request is taken; it then holds in its response cycle until
// the output register frees.
// reset clears the valid bits, the hit counters and the mapping mode at once;
// no clearing pass is needed and the block takes requests straight away.
module dm_fa_lfu_read_cache
  import dfl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // request
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ADDR_W-1:0]   address_i,
  input  logic [WORD_W-1:0]   fill_word_0_i,
  input  logic [WORD_W-1:0]   fill_word_1_i,
  input  logic [WORD_W-1:0]   fill_word_2_i,
  input  logic [WORD_W-1:0]   fill_word_3_i,
  // result
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [WORD_W-1:0]   read_data_o,
  output logic                hit_o,
  output logic                replaced_o,
  output logic                failed_o,
  output logic [USED_W-1:0]   line_used_o,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [0:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // configuration register
  logic mode_q;

  assign pready = 1'b1;
  assign prdata = {31'b0, mode_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_DIRECT;
    end else if (psel && penable && pwrite && ((32'(paddr) >> 2) == REG_MAPPING_MODE)) begin
      mode_q <= pwdata[0];
    end
  end

  // line state
  logic [LINES-1:0]      valid_q;
  logic [TAG_W-1:0]      tag_q   [LINES];
  logic [COUNT_BITS-1:0] count_q [LINES];

  // block memory, one row per line
  logic [ROW_W-1:0] data_mem [LINES];
  logic [ROW_W-1:0] rd_row_q;

  state_e state_q, state_d;
  logic   in_fire, resp_load;

  assign in_fire = in_valid_i && in_ready_o;

  // address split and range check
  logic                   addr_bad;
  logic [BLOCK_BITS-1:0]  block;
  logic [OFFSET_BITS-1:0] offset;
  logic [LINE_W-1:0]      dm_line;
  logic [TAG_W-1:0]       req_tag;
  logic [ROW_W-1:0]       fill_row;

  assign addr_bad = (32'(address_i) >> ADDR_SPAN_BITS) != 32'd0;
  assign block    = address_i[OFFSET_BITS +: BLOCK_BITS];
  assign offset   = address_i[OFFSET_BITS-1:0];
  assign dm_line  = block[INDEX_BITS-1:0];
  assign req_tag  = (mode_q == MODE_DIRECT) ? TAG_W'(block >> INDEX_BITS) : block;
  assign fill_row = {fill_word_3_i, fill_word_2_i, fill_word_1_i, fill_word_0_i};

  // lookup and victim choice
  logic              look_hit, look_repl;
  logic [LINE_W-1:0] look_line;

  always_comb begin
    logic              fa_hit, fa_empty;
    logic [LINE_W-1:0] fa_hit_line, fa_empty_line, lfu_line;
    logic [COUNT_BITS-1:0] best;
    fa_hit        = 1'b0;
    fa_hit_line   = '0;
    fa_empty      = 1'b0;
    fa_empty_line = '0;
    lfu_line      = '0;
    best          = count_q[0];
    for (int i = LINES - 1; i >= 0; i--) begin
      if (valid_q[i] && (tag_q[i] == req_tag)) begin
        fa_hit      = 1'b1;
        fa_hit_line = LINE_W'(i);
      end
      if (!valid_q[i]) begin
        fa_empty      = 1'b1;
        fa_empty_line = LINE_W'(i);
      end
    end
    for (int i = 1; i < LINES; i++) begin
      if (count_q[i] < best) begin
        best     = count_q[i];
        lfu_line = LINE_W'(i);
      end
    end
    if (mode_q == MODE_DIRECT) begin
      look_line = dm_line;
      look_hit  = valid_q[dm_line] && (tag_q[dm_line] == req_tag);
      look_repl = !look_hit && valid_q[dm_line];
    end else begin
      look_hit  = fa_hit;
      look_repl = !fa_hit && !fa_empty;
      if (fa_hit) begin
        look_line = fa_hit_line;
      end else if (fa_empty) begin
        look_line = fa_empty_line;
      end else begin
        look_line = lfu_line;
      end
    end
  end

  // line state update at accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < LINES; i++) begin
        count_q[i] <= '0;
      end
    end else if (in_fire && !addr_bad) begin
      if (look_hit) begin
        if (count_q[look_line] != COUNT_MAX) begin
          count_q[look_line] <= count_q[look_line] + COUNT_BITS'(1);
        end
      end else begin
        valid_q[look_line] <= 1'b1;
        count_q[look_line] <= COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && !addr_bad && !look_hit) begin
      tag_q[look_line] <= req_tag;
    end
  end

  // block memory: refill write on a miss, row read on a hit
  always_ff @(posedge clk_i) begin
    if (in_fire && !addr_bad) begin
      if (look_hit) begin
        rd_row_q <= data_mem[look_line];
      end else begin
        data_mem[look_line] <= fill_row;
      end
    end
  end

  // request held for the response cycle, refill word forwarded
  logic                   hit_q, repl_q, fail_q;
  logic [LINE_W-1:0]      line_q;
  logic [OFFSET_BITS-1:0] offset_q;
  logic [WORD_W-1:0]      miss_word_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      hit_q       <= look_hit && !addr_bad;
      repl_q      <= look_repl && !addr_bad;
      fail_q      <= addr_bad;
      line_q      <= addr_bad ? '0 : look_line;
      offset_q    <= offset;
      miss_word_q <= fill_row[32'(offset) * WORD_W +: WORD_W];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (resp_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready_o = 1'b0;
    resp_load  = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_RESP: resp_load = !out_valid_o || out_ready_i;
      default: begin
        in_ready_o = 1'b0;
        resp_load  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // output register
  logic [WORD_W-1:0] resp_word;

  always_comb begin
    if (fail_q) begin
      resp_word = '0;
    end else if (hit_q) begin
      resp_word = rd_row_q[32'(offset_q) * WORD_W +: WORD_W];
    end else begin
      resp_word = miss_word_q;
    end
  end

  logic out_valid_q;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (resp_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (resp_load) begin
      read_data_o <= resp_word;
      hit_o       <= hit_q;
      replaced_o  <= repl_q;
      failed_o    <= fail_q;
      line_used_o <= USED_W'(line_q);
    end
  end

  // checks
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && failed_o |-> !hit_o && !replaced_o && (read_data_o == '0)
      && (line_used_o == '0))
    else $error("failed result carries data or flags");

  a_hit_not_repl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && replaced_o))
    else $error("result flags both hit and replacement");

  a_fill_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !addr_bad |=> valid_q[line_q])
    else $error("chosen line not valid after access");

  a_hit_was_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !addr_bad && look_hit |-> valid_q[look_line])
    else $error("hit on an empty line");

  a_no_accept_in_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("request taken during response cycle");

endmodule
